@@ design/u2u_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package u2u_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Per-length offsets removed from the accumulated value
	localparam logic [31:0] OFFSET_LEN2 = 32'h0000_3080;
	localparam logic [31:0] OFFSET_LEN3 = 32'h000E_2080;
	localparam logic [31:0] OFFSET_LEN4 = 32'h03C8_2080;
	localparam logic [31:0] OFFSET_LEN5 = 32'hFA08_2080;
	localparam logic [31:0] OFFSET_LEN6 = 32'h8208_2080;

	localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
	localparam logic [15:0] HIGH_BASE  = 16'hD800;
	localparam logic [5:0]  LOW_PREFIX = 6'b110111;

	// Queue status seen by the front and back sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Offset to subtract for a sequence of the given total length
	function automatic logic [31:0] len_offset(input logic [2:0] total);
		logic [31:0] off;
		case (total)
			3'd2: off = OFFSET_LEN2;
			3'd3: off = OFFSET_LEN3;
			3'd4: off = OFFSET_LEN4;
			3'd5: off = OFFSET_LEN5;
			3'd6: off = OFFSET_LEN6;
			default: off = '0;
		endcase
		return off;
	endfunction

	// Sequence length implied by a lead byte (0xC0 and up)
	function automatic logic [2:0] lead_total(input logic [7:0] b);
		logic [2:0] t;
		case (b) inside
			[8'hFC:8'hFF]: t = 3'd6;
			[8'hF8:8'hFB]: t = 3'd5;
			[8'hF0:8'hF7]: t = 3'd4;
			[8'hE0:8'hEF]: t = 3'd3;
			default:       t = 3'd2;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

@@ design/u2u_front.sv @@
// Front side: takes bytes, tracks the pending sequence, pushes finished code points.
`timescale 1ns / 1ps
`default_nettype none
module u2u_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        byte_req,
	input  wire logic              end_of_text,
	input  wire u2u_pkg::q_status_t q_status,
	output logic                   push,
	output logic [31:0]            push_cp
);
	import u2u_pkg::*;

	logic [2:0]  rem_q, tot_q;
	logic [31:0] part_q;
	logic [2:0]  rem_d, tot_d;
	logic [31:0] part_d;
	logic [31:0] acc;
	logic [2:0]  rem_dec;
	logic        is_cont, accept, emit;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign is_cont  = (byte_req[7:6] == 2'b10);
	assign acc      = {part_q[25:0], 6'b0} + {24'b0, byte_req};
	assign rem_dec  = rem_q - 3'd1;

	// Sequence tracking and code point formation
	always_comb begin
		rem_d   = rem_q;
		tot_d   = tot_q;
		part_d  = part_q;
		emit    = 1'b0;
		push_cp = {24'b0, byte_req};
		if (rem_q != 3'd0 && is_cont) begin
			if (rem_dec == 3'd0) begin
				emit    = 1'b1;
				push_cp = acc - len_offset(tot_q);
				rem_d   = '0;
				tot_d   = '0;
				part_d  = '0;
			end else begin
				rem_d  = rem_dec;
				part_d = acc;
			end
		end else begin
			// abandon any pending sequence, then treat byte as a lead (a stray continuation byte is dropped)
			rem_d  = '0;
			tot_d  = '0;
			part_d = '0;
			if (!byte_req[7]) begin
				emit = 1'b1;
			end else if (!is_cont) begin
				tot_d  = lead_total(byte_req);
				rem_d  = lead_total(byte_req) - 3'd1;
				part_d = {24'b0, byte_req};
			end
		end
		if (end_of_text) begin
			rem_d  = '0;
			tot_d  = '0;
			part_d = '0;
		end
	end

	assign push = accept && emit;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			tot_q  <= '0;
			part_q <= '0;
		end else if (accept) begin
			rem_q  <= rem_d;
			tot_q  <= tot_d;
			part_q <= part_d;
		end
	end

endmodule
`default_nettype wire

@@ design/u2u_queue.sv @@
// Short code point queue between the front and back sides.
`timescale 1ns / 1ps
`default_nettype none
module u2u_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [31:0] push_cp,
	input  wire logic        pop,
	output logic [31:0]      head_cp,
	output u2u_pkg::q_status_t status
);
	import u2u_pkg::*;

	logic [31:0]      mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push, do_pop;

	assign status.full  = (cnt_q == QCntW'(QDepth));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_cp      = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cp;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/u2u_back.sv @@
// Back side: splits code points into UTF-16 units and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module u2u_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [31:0]        head_cp,
	input  wire u2u_pkg::q_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             unit,
	output logic                    last_of_run
);
	import u2u_pkg::*;

	logic        out_valid_q, last_q, low_pend_q;
	logic [15:0] unit_q;
	logic [31:0] v;
	logic        load, is_pair;
	logic [15:0] unit_d;
	logic        last_d;

	assign v       = head_cp - SUPP_BASE;
	assign is_pair = (head_cp >= SUPP_BASE);
	assign load    = !q_status.empty && (!out_valid_q || out_ready);

	// Unit selection: single unit, high half or low half of a pair
	always_comb begin
		if (low_pend_q) begin
			unit_d = {LOW_PREFIX, v[9:0]};
			last_d = 1'b1;
		end else if (is_pair) begin
			unit_d = HIGH_BASE + v[25:10];
			last_d = 1'b0;
		end else begin
			unit_d = head_cp[15:0];
			last_d = 1'b1;
		end
	end

	assign pop = load && last_d;

	// Output register and pair phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			low_pend_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				low_pend_q  <= !last_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= unit_d;
			last_q <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign unit        = unit_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

@@ design/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    byte_req[7:0], end_of_text
//  out      source     out_valid/out_ready  unit[15:0], last_of_run
//
// One byte is accepted per cycle while the two-entry code point queue has room.
// Each code point leaves as one unit, or as a surrogate pair, via the single output
// register. A finished code point is written into the queue and then loaded into
// the output register before its first unit appears. Reset clears the pending
// sequence, queue pointers and output valid flag; either side may stall without data loss.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_utf16_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_req,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      unit,
	output logic             last_of_run
);
	import u2u_pkg::*;

	q_status_t   q_status;
	logic        push, pop;
	logic [31:0] push_cp, head_cp;

	u2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_req   (byte_req),
		.end_of_text(end_of_text),
		.q_status   (q_status),
		.push       (push),
		.push_cp    (push_cp)
	);

	u2u_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_cp(push_cp),
		.pop    (pop),
		.head_cp(head_cp),
		.status (q_status)
	);

	u2u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cp    (head_cp),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit       (unit),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

@@ design/u2u_checker.sv @@
// Port-level checks for the transcoder and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module u2u_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] unit,
	input wire logic        last_of_run
);
	logic [7:0] credit_q;
	logic       in_fire, run_end;

	assign in_fire = in_valid && in_ready;
	assign run_end = out_valid && out_ready && last_of_run;

	// Bytes accepted but whose run has not ended yet (saturating)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (in_fire && !run_end) begin
			if (credit_q != 8'hFF) begin
				credit_q <= credit_q + 8'd1;
			end
		end else if (run_end && !in_fire) begin
			if (credit_q != 8'hFF && credit_q != 8'd0) begin
				credit_q <= credit_q - 8'd1;
			end
		end
	end

	// A stalled unit holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit) && $stable(last_of_run))
		else $error("output unit changed while stalled");

	// The low surrogate follows its high half in the very next cycle
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=>
			out_valid && last_of_run && unit[15:10] == 6'b110111)
		else $error("low surrogate did not follow high half");

	// No run ends without an item that caused it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |-> credit_q != 8'd0)
		else $error("unit run with no matching input item");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_u2u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.unit       (unit),
	.last_of_run(last_of_run)
);
`default_nettype wire
